// ----- rtl/voice_allocator_oldest_steal_unit_macros.svh -----
// Assertion helpers shared by the voice allocator RTL.
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_UNIT_MACROS_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VAOS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VAOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vaos_pkg.sv -----
`timescale 1ns / 1ps

package vaos_pkg;

    localparam int VOICES_DEF = 8;
    localparam int AGE_W      = 32;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int SLOT_W     = 3;
    localparam int MASK_W     = 8;
    localparam int FIN_W      = 3;
    localparam int LIMIT_W    = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    // wide enough for any voice count or index up to 32
    localparam int CMP_W      = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    localparam logic [CFG_ADDR_W-1:0] CFG_VOICE_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_LOADED = 1'b1;

    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_ALL_OFF  = 2'd2,
        MODE_FINISHED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic step;
        logic first;
    } scan_ctl_t;

endpackage

// ----- rtl/vaos_scan.sv -----
`timescale 1ns / 1ps

// One voice per step: track the first free voice and the oldest voice seen.
module vaos_scan #(
    parameter int VOICES = vaos_pkg::VOICES_DEF,
    localparam int IdxW  = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  vaos_pkg::scan_ctl_t       ctl,
    input  logic [IdxW-1:0]           idx,
    input  logic                      active,
    input  logic [vaos_pkg::AGE_W-1:0] age,
    output logic [IdxW-1:0]           pick
);

    logic                       found_reg;
    logic [IdxW-1:0]            free_idx_reg;
    logic [IdxW-1:0]            best_idx_reg;
    logic [vaos_pkg::AGE_W-1:0] best_age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.step) begin
            if (ctl.first) begin
                found_reg <= !active;
            end else if (!found_reg && !active) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            if (ctl.first) begin
                free_idx_reg <= idx;
                best_idx_reg <= idx;
                best_age_reg <= age;
            end else begin
                if (!found_reg && !active) begin
                    free_idx_reg <= idx;
                end
                // strict compare keeps the lowest index on ties
                if (age < best_age_reg) begin
                    best_idx_reg <= idx;
                    best_age_reg <= age;
                end
            end
        end
    end

    assign pick = found_reg ? free_idx_reg : best_idx_reg;

endmodule

// ----- rtl/voice_allocator_oldest_steal_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Beat contents
// s_        in   s_valid/s_ready    mode, note_number, velocity, finished_voice
// m_        out  m_valid/m_ready    accepted, slot, stolen, velocity_out, masks
// cfg_      in   cfg_we             cfg_addr selects voice_limit or sample_loaded
//
// A note-on with a sample loaded scans the usable voices one per cycle through
// a single age comparator, then passes through commit to the result register;
// m_valid and s_ready rise together as commit loads the result. Any other beat
// skips the scan and goes straight from idle to commit.
// s_ready is high only while idle; a waiting result beat holds the next item in
// commit, which keeps s_ready low. Reset (aresetn, synchronous, active low)
// clears all voices, sets the age counter to 1, voice_limit to 8, sample_loaded to 0.
`include "voice_allocator_oldest_steal_unit_macros.svh"

module voice_allocator_oldest_steal_unit #(
    parameter int VOICES = vaos_pkg::VOICES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [vaos_pkg::NOTE_W-1:0]     s_note_number,
    input  logic [vaos_pkg::VEL_W-1:0]      s_velocity,
    input  logic [vaos_pkg::FIN_W-1:0]      s_finished_voice,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic [vaos_pkg::SLOT_W-1:0]     m_slot,
    output logic                            m_stolen,
    output logic [vaos_pkg::VEL_W-1:0]      m_velocity_out,
    output logic [vaos_pkg::MASK_W-1:0]     m_released_mask,
    output logic [vaos_pkg::MASK_W-1:0]     m_active_mask,
    input  logic                            cfg_we,
    input  logic [vaos_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vaos_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IdxW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CntW  = $clog2(VOICES + 1);
    localparam int CmpW  = vaos_pkg::CMP_W;
    localparam int MaskW = vaos_pkg::MASK_W;
    localparam int PadW  = (VOICES > MaskW) ? VOICES : MaskW;
    localparam int AgeW  = vaos_pkg::AGE_W;
    localparam int NoteW = vaos_pkg::NOTE_W;
    localparam int VelW  = vaos_pkg::VEL_W;
    localparam int SlotW = vaos_pkg::SLOT_W;
    localparam int FinW  = vaos_pkg::FIN_W;
    localparam int LimW  = vaos_pkg::LIMIT_W;

    // ---------------------------------------------------------------- config
    logic [LimW-1:0] voice_limit_reg;
    logic            sample_loaded_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_limit_reg   <= vaos_pkg::LIMIT_RESET;
            sample_loaded_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                vaos_pkg::CFG_VOICE_LIMIT: begin
                    voice_limit_reg <= cfg_wdata[LimW-1:0];
                end
                vaos_pkg::CFG_SAMPLE_LOADED: begin
                    sample_loaded_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp polyphony to 1..VOICES.
    logic [CntW-1:0] usable;
    always_comb begin
        if (voice_limit_reg == '0) begin
            usable = CntW'(1);
        end else if (CmpW'(voice_limit_reg) > CmpW'(VOICES)) begin
            usable = CntW'(VOICES);
        end else begin
            usable = CntW'(voice_limit_reg);
        end
    end

    // ----------------------------------------------------------- voice table
    logic [VOICES-1:0] active_reg, active_next;
    logic [VOICES-1:0] gate_reg, gate_next;
    logic [NoteW-1:0]  note_reg [VOICES];
    logic [AgeW-1:0]   age_reg  [VOICES];
    logic [AgeW-1:0]   age_cnt_reg;

    // ------------------------------------------------------- captured beat
    vaos_pkg::mode_t  mode_reg;
    logic [NoteW-1:0] in_note_reg;
    logic [VelW-1:0]  in_vel_reg;
    logic [FinW-1:0]  in_fin_reg;

    // ------------------------------------------------------------- sequencer
    vaos_pkg::state_t state_reg, state_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             accept_in;
    logic             out_load;
    logic             scan_last;

    assign s_ready   = (state_reg == vaos_pkg::ST_IDLE);
    assign accept_in = s_valid && s_ready;
    assign scan_last = (CmpW'(idx_reg) + CmpW'(1)) == CmpW'(usable);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vaos_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            vaos_pkg::ST_IDLE: begin
                idx_next = '0;
                if (accept_in) begin
                    // only an allocating note-on needs the voice scan
                    if ((vaos_pkg::mode_t'(s_mode) == vaos_pkg::MODE_NOTE_ON)
                            && sample_loaded_reg) begin
                        state_next = vaos_pkg::ST_SCAN;
                    end else begin
                        state_next = vaos_pkg::ST_COMMIT;
                    end
                end
            end
            vaos_pkg::ST_SCAN: begin
                // advance one voice per cycle through the shared comparator
                if (scan_last) begin
                    state_next = vaos_pkg::ST_COMMIT;
                end else begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            vaos_pkg::ST_COMMIT: begin
                // hold until the result register is free
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = vaos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vaos_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            mode_reg    <= vaos_pkg::mode_t'(s_mode);
            in_note_reg <= s_note_number;
            in_vel_reg  <= s_velocity;
            in_fin_reg  <= s_finished_voice;
        end
    end

    // ------------------------------------------------------ shared scan unit
    vaos_pkg::scan_ctl_t scan_ctl;
    logic [IdxW-1:0]     pick;

    assign scan_ctl.step  = (state_reg == vaos_pkg::ST_SCAN);
    assign scan_ctl.first = (idx_reg == '0);

    vaos_scan #(
        .VOICES (VOICES)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .idx     (idx_reg),
        .active  (active_reg[idx_reg]),
        .age     (age_reg[idx_reg]),
        .pick    (pick)
    );

    // ---------------------------------------------------------- commit step
    logic              alloc;
    logic [VOICES-1:0] hit;
    logic [VOICES-1:0] pick_sel;
    logic [VOICES-1:0] fin_sel;
    logic [CmpW-1:0]   pick_wide;

    assign alloc     = (mode_reg == vaos_pkg::MODE_NOTE_ON) && sample_loaded_reg;
    assign pick_wide = CmpW'(pick);

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            hit[i]      = active_reg[i] && (note_reg[i] == in_note_reg);
            pick_sel[i] = (pick_wide == CmpW'(i));
            fin_sel[i]  = (CmpW'(in_fin_reg) == CmpW'(i));
        end
    end

    always_comb begin
        active_next = active_reg;
        gate_next   = gate_reg;
        unique case (mode_reg)
            vaos_pkg::MODE_NOTE_ON: begin
                if (alloc) begin
                    active_next = active_reg | pick_sel;
                    gate_next   = gate_reg | pick_sel;
                end
            end
            vaos_pkg::MODE_NOTE_OFF: begin
                gate_next = gate_reg & ~hit;
            end
            vaos_pkg::MODE_ALL_OFF: begin
                active_next = '0;
            end
            vaos_pkg::MODE_FINISHED: begin
                // an index past the table selects nothing
                active_next = active_reg & ~fin_sel;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            gate_reg    <= '0;
            age_cnt_reg <= AgeW'(1);
            for (int i = 0; i < VOICES; i++) begin
                note_reg[i] <= '0;
                age_reg[i]  <= '0;
            end
        end else if (out_load) begin
            active_reg <= active_next;
            gate_reg   <= gate_next;
            if (alloc) begin
                age_cnt_reg <= age_cnt_reg + AgeW'(1);
                for (int i = 0; i < VOICES; i++) begin
                    if (pick_sel[i]) begin
                        note_reg[i] <= in_note_reg;
                        age_reg[i]  <= age_cnt_reg;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------- result beat
    logic [PadW-1:0] active_pad;
    logic [PadW-1:0] release_pad;
    logic            m_valid_reg;
    logic            m_accepted_reg;
    logic [SlotW-1:0] m_slot_reg;
    logic            m_stolen_reg;
    logic [VelW-1:0] m_vel_reg;
    logic [MaskW-1:0] m_released_reg;
    logic [MaskW-1:0] m_active_reg;

    assign active_pad  = PadW'(active_next);
    assign release_pad = PadW'(hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_accepted_reg <= alloc;
            m_slot_reg     <= alloc ? pick_wide[SlotW-1:0] : '0;
            m_stolen_reg   <= alloc && active_reg[pick];
            m_vel_reg      <= alloc ? in_vel_reg : '0;
            m_released_reg <= (mode_reg == vaos_pkg::MODE_NOTE_OFF)
                              ? release_pad[MaskW-1:0] : '0;
            m_active_reg   <= active_pad[MaskW-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_slot          = m_slot_reg;
    assign m_stolen        = m_stolen_reg;
    assign m_velocity_out  = m_vel_reg;
    assign m_released_mask = m_released_reg;
    assign m_active_mask   = m_active_reg;

    // ------------------------------------------------------------ assertions
    `VAOS_ASSERT_IMPL(a_scan_in_range, state_reg == vaos_pkg::ST_SCAN, CmpW'(idx_reg) < CmpW'(usable), "scan index past polyphony")
    `VAOS_ASSERT_IMPL(a_stolen_needs_accept, m_valid_reg && m_stolen_reg, m_accepted_reg, "stolen without allocation")
    `VAOS_ASSERT_IMPL(a_release_only_note_off, m_valid_reg && (m_released_reg != '0), !m_accepted_reg, "release mask on allocation")
    `VAOS_ASSERT_NEXT(a_alloc_sets_active, out_load && alloc, active_reg[pick_wide[IdxW-1:0]] && gate_reg[pick_wide[IdxW-1:0]], "allocated voice not active")

endmodule
